// File: hdl/hsp_pkg.sv
// ----------------------------------------------------------------------------
// hsp_pkg
// Shared types and constants for the hull support point block.
// ----------------------------------------------------------------------------
package hsp_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int FRAC_BITS    = 16;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = IDX_W + 1;

    typedef enum logic [1:0] {
        OP_LOAD_VERTEX = 2'd0,
        OP_LOAD_PLACE  = 2'd1,
        OP_LOAD_INV    = 2'd2,
        OP_QUERY       = 2'd3
    } opcode_t;

    // Multiply-accumulate source select
    typedef enum logic [1:0] {
        SRC_INV   = 2'd0,
        SRC_SCORE = 2'd1,
        SRC_PLACE = 2'd2
    } src_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INV_MUL,
        ST_INV_SUM,
        ST_SCAN_RD,
        ST_SCAN_MUL,
        ST_SCAN_SUM,
        ST_SCAN_CMP,
        ST_BEST_RD,
        ST_PLACE_MUL,
        ST_PLACE_SUM,
        ST_OUT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load_in;      // capture input transaction
        logic       write_store;  // perform a load
        logic       start_scan;   // clear scan state
        src_t       src;
        logic [1:0] row;          // matrix row for transforms
        logic       mul;          // register products
        logic       sum;          // register saturated sum
        logic       rd_vertex;    // read store at scan index
        logic       rd_best;      // read store at best index
        logic       compare;      // score against best
        logic       set_out;      // latch result
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_query;
        logic scan_done;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

// File: hdl/hsp_ctrl.sv
// ----------------------------------------------------------------------------
// hsp_ctrl
// Sequencer: loads, inverse transform, vertex scan, placement, result.
// ----------------------------------------------------------------------------
module hsp_ctrl
    import hsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [1:0] row_reg, row_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        cmd        = '0;
        cmd.row    = row_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // result register must be free before a new transaction is taken
                in_ready = !out_valid || out_ready;
                if (in_valid && in_ready)
                begin
                    cmd.load_in = 1'b1;
                    cmd.write_store = 1'b1;
                    if (status.is_query)
                    begin
                        state_next = ST_INV_MUL;
                        row_next   = '0;
                    end
                end
            end
            ST_INV_MUL:
            begin
                cmd.src = SRC_INV;
                cmd.mul = 1'b1;
                state_next = ST_INV_SUM;
            end
            ST_INV_SUM:
            begin
                cmd.src = SRC_INV;
                cmd.sum = 1'b1;
                if (row_reg == 2'd2)
                begin
                    cmd.start_scan = 1'b1;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    row_next = row_reg + 2'd1;
                    state_next = ST_INV_MUL;
                end
            end
            ST_SCAN_RD:
            begin
                if (status.scan_done)
                begin
                    cmd.rd_best = 1'b1;
                    state_next = ST_BEST_RD;
                end
                else
                begin
                    cmd.rd_vertex = 1'b1;
                    state_next = ST_SCAN_MUL;
                end
            end
            ST_SCAN_MUL:
            begin
                cmd.src = SRC_SCORE;
                cmd.mul = 1'b1;
                state_next = ST_SCAN_SUM;
            end
            ST_SCAN_SUM:
            begin
                cmd.src = SRC_SCORE;
                cmd.sum = 1'b1;
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                cmd.compare = 1'b1;
                state_next = ST_SCAN_RD;
            end
            ST_BEST_RD:
            begin
                row_next = '0;
                state_next = ST_PLACE_MUL;
            end
            ST_PLACE_MUL:
            begin
                cmd.src = SRC_PLACE;
                cmd.mul = 1'b1;
                state_next = ST_PLACE_SUM;
            end
            ST_PLACE_SUM:
            begin
                cmd.src = SRC_PLACE;
                cmd.sum = 1'b1;
                if (row_reg == 2'd2)
                    state_next = ST_OUT;
                else
                begin
                    row_next = row_reg + 2'd1;
                    state_next = ST_PLACE_MUL;
                end
            end
            ST_OUT:
            begin
                cmd.set_out = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// File: hdl/hsp_datapath.sv
// ----------------------------------------------------------------------------
// hsp_datapath
// Vertex store, matrices, shared three-lane multiplier and argmax scan.
// ----------------------------------------------------------------------------
module hsp_datapath
    import hsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         opcode,
    input  logic [9:0]         slot,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    input  logic [10:0]        vertex_count,
    input  cmd_t               cmd,
    output status_t            status,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic [9:0]         chosen_vertex,
    output logic               found
);

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    logic [95:0]        store_mem [MAX_VERTICES];
    logic [95:0]        rd_data_reg;
    logic signed [31:0] place_reg [12];
    logic signed [31:0] inv_reg   [12];
    logic signed [31:0] dir_reg   [3];
    logic signed [31:0] u_reg     [3];
    logic signed [31:0] pt_reg    [3];
    logic signed [63:0] prod_reg  [3];
    logic signed [31:0] score_reg, best_score_reg;
    logic [CNT_W-1:0]   scan_idx_reg, cmp_idx_reg, best_idx_reg, n_lim;
    logic               have_reg;
    logic               out_valid_reg;
    logic signed [31:0] pt_out_reg [3];
    logic [9:0]         chosen_reg;
    logic               found_reg;

    logic signed [31:0] ma [3];
    logic signed [31:0] mb [3];
    logic signed [31:0] addend;
    logic signed [65:0] acc;
    logic signed [31:0] sum_sat;
    logic signed [31:0] v_in [3];

    assign status.is_query = (opcode_t'(opcode) == OP_QUERY);
    assign n_lim = (vertex_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                          : vertex_count[CNT_W-1:0];
    assign status.scan_done = (scan_idx_reg >= n_lim);

    // Vertex store, read port registered
    always_ff @(posedge clk)
    begin
        if (cmd.write_store && opcode_t'(opcode) == OP_LOAD_VERTEX)
            store_mem[slot[IDX_W-1:0]] <= {coord_z, coord_y, coord_x};
        if (cmd.rd_vertex)
            rd_data_reg <= store_mem[scan_idx_reg[IDX_W-1:0]];
        else if (cmd.rd_best)
            rd_data_reg <= store_mem[best_idx_reg[IDX_W-1:0]];
    end

    // Matrices, identity at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 12; i++)
            begin
                place_reg[i] <= (i == 0 || i == 5 || i == 10) ? ONE : '0;
                inv_reg[i]   <= (i == 0 || i == 5 || i == 10) ? ONE : '0;
            end
        end
        else if (cmd.write_store && slot < 10'd12)
        begin
            if (opcode_t'(opcode) == OP_LOAD_PLACE)
                place_reg[slot[3:0]] <= coord_x;
            else if (opcode_t'(opcode) == OP_LOAD_INV)
                inv_reg[slot[3:0]] <= coord_x;
        end
    end

    // Operand selection; an empty hull places the origin
    always_comb
    begin
        v_in[0] = have_reg ? rd_data_reg[31:0]  : '0;
        v_in[1] = have_reg ? rd_data_reg[63:32] : '0;
        v_in[2] = have_reg ? rd_data_reg[95:64] : '0;
        addend  = '0;
        for (int k = 0; k < 3; k++)
        begin
            ma[k] = '0;
            mb[k] = '0;
        end
        unique case (cmd.src)
            SRC_INV:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    ma[k] = inv_reg[{cmd.row, 2'(k)}];
                    mb[k] = dir_reg[k];
                end
            end
            SRC_SCORE:
            begin
                ma[0] = rd_data_reg[31:0];
                ma[1] = rd_data_reg[63:32];
                ma[2] = rd_data_reg[95:64];
                for (int k = 0; k < 3; k++)
                    mb[k] = u_reg[k];
            end
            SRC_PLACE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    ma[k] = place_reg[{cmd.row, 2'(k)}];
                    mb[k] = v_in[k];
                end
                addend = place_reg[{cmd.row, 2'd3}];
            end
            default:
            begin
                addend = '0;
            end
        endcase
        // arithmetic shift floors toward minus infinity
        acc = 66'(prod_reg[0] >>> FRAC_BITS) + 66'(prod_reg[1] >>> FRAC_BITS)
            + 66'(prod_reg[2] >>> FRAC_BITS) + 66'(addend);
        sum_sat = sat32(acc);
    end

    // Products and sums
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            dir_reg[0] <= coord_x;
            dir_reg[1] <= coord_y;
            dir_reg[2] <= coord_z;
        end
        if (cmd.mul)
            for (int k = 0; k < 3; k++)
                prod_reg[k] <= 64'(ma[k]) * 64'(mb[k]);
        if (cmd.sum)
        begin
            unique case (cmd.src)
                SRC_INV:   u_reg[cmd.row]  <= sum_sat;
                SRC_SCORE: score_reg       <= sum_sat;
                SRC_PLACE: pt_reg[cmd.row] <= sum_sat;
                default:   score_reg       <= sum_sat;
            endcase
        end
        if (cmd.rd_vertex)
            cmp_idx_reg <= scan_idx_reg;
        if (cmd.compare && (!have_reg || score_reg > best_score_reg))
            best_score_reg <= score_reg;
    end

    // Scan control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            best_idx_reg <= '0;
            have_reg     <= 1'b0;
        end
        else if (cmd.start_scan)
        begin
            scan_idx_reg <= '0;
            best_idx_reg <= '0;
            have_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.rd_vertex)
                scan_idx_reg <= scan_idx_reg + 1'b1;
            if (cmd.compare && (!have_reg || score_reg > best_score_reg))
            begin
                have_reg     <= 1'b1;
                best_idx_reg <= cmp_idx_reg;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.set_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_out)
        begin
            for (int k = 0; k < 3; k++)
                pt_out_reg[k] <= pt_reg[k];
            chosen_reg <= have_reg ? best_idx_reg[9:0] : '0;
            found_reg  <= have_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign point_x       = pt_out_reg[0];
    assign point_y       = pt_out_reg[1];
    assign point_z       = pt_out_reg[2];
    assign chosen_vertex = chosen_reg;
    assign found         = found_reg;

endmodule

// File: hdl/hull_support_point.sv
// ----------------------------------------------------------------------------
// hull_support_point
// Support point of a placed convex hull over a stored vertex set.
// ----------------------------------------------------------------------------
// Loads are taken in the idle state and may follow back to back. A query
// runs the inverse transform (multiply and sum for each row), then for each
// vertex a read, multiply, sum and compare through one shared three-lane
// multiplier, then the end check, best read, placement and output.
// The next transaction is taken in idle again; a waiting result holds input.
// Reset (asynchronous, active low) sets both matrices to identity and the
// vertex count to zero; the vertex store is not cleared.
module hull_support_point
    import hsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [10:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [9:0]         slot,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic [9:0]         chosen_vertex,
    output logic               found
);

    logic [10:0] vertex_count_reg;
    cmd_t        cmd;
    status_t     status;

    assign cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vertex_count_reg <= '0;
        else if (cfg_valid)
            vertex_count_reg <= cfg_data;
    end

    hsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    hsp_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .opcode        (opcode),
        .slot          (slot),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .vertex_count  (vertex_count_reg),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .chosen_vertex (chosen_vertex),
        .found         (found)
    );

endmodule

// File: tb/hull_support_point_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hull_support_point_tb
// Self-checking bench for the hull support point block. Loads and queries go
// through a bursty driver; a predictor of the support mapping builds the
// expected points, and a monitor with its own stall pattern compares them.
// ----------------------------------------------------------------------------
module hull_support_point_tb;
    import hsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int NV_USED        = 64;

    typedef struct packed {
        opcode_t            op;
        logic [9:0]         slot;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
    } hull_txn_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [9:0]         idx;
        logic               hit;
    } support_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [10:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] opcode = '0;
    logic [9:0] slot = '0;
    logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] point_x, point_y, point_z;
    logic [9:0] chosen_vertex;
    logic found;

    hull_txn_t pending_q[$];
    support_t  support_q[$];
    int        n_fail = 0;
    int        idle_cycles = 0;
    bit        txn_seen;

    // predictor state
    logic signed [31:0] pred_vtx[MAX_VERTICES][3];
    logic signed [31:0] pred_place[12];
    logic signed [31:0] pred_inv[12];
    logic [10:0]        pred_count;

    always #2 clk = ~clk;

    hull_support_point u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .slot(slot),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .chosen_vertex(chosen_vertex), .found(found)
    );

    // Q16.16 product, floor shift
    function automatic logic signed [65:0] fx_mul(logic signed [31:0] a,
                                                   logic signed [31:0] b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b);
        return p >>> FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        if (v < -66'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] mat_row(logic signed [31:0] m[12],
        int r, logic signed [31:0] x, logic signed [31:0] y,
        logic signed [31:0] z, bit affine);
        logic signed [65:0] s;
        s = fx_mul(m[r*4], x) + fx_mul(m[r*4+1], y) + fx_mul(m[r*4+2], z);
        if (affine)
            s = s + 66'(m[r*4+3]);
        return clamp32(s);
    endfunction

    function automatic void reset_matrices();
        for (int k = 0; k < 12; k++)
        begin
            pred_place[k] = (k == 0 || k == 5 || k == 10) ? 32'sd65536 : 32'sd0;
            pred_inv[k] = pred_place[k];
        end
    endfunction

    // apply one transaction; queue the support point for queries
    function automatic void predict_support(hull_txn_t t);
        logic signed [31:0] u[3];
        logic signed [31:0] s, best_s, bx, by, bz;
        int n, best;
        bit have;
        support_t exp_pt;
        best_s = '0;
        best = 0;
        have = 0;
        case (t.op)
            OP_LOAD_VERTEX:
            begin
                pred_vtx[t.slot][0] = t.cx;
                pred_vtx[t.slot][1] = t.cy;
                pred_vtx[t.slot][2] = t.cz;
            end
            OP_LOAD_PLACE: if (t.slot < 12) pred_place[t.slot] = t.cx;
            OP_LOAD_INV:   if (t.slot < 12) pred_inv[t.slot] = t.cx;
            default:
            begin
                n = (pred_count > MAX_VERTICES) ? MAX_VERTICES : int'(pred_count);
                for (int r = 0; r < 3; r++)
                    u[r] = mat_row(pred_inv, r, t.cx, t.cy, t.cz, 0);
                for (int i = 0; i < n; i++)
                begin
                    s = clamp32(fx_mul(pred_vtx[i][0], u[0]) +
                        fx_mul(pred_vtx[i][1], u[1]) + fx_mul(pred_vtx[i][2], u[2]));
                    if (!have || s > best_s)
                    begin
                        have = 1;
                        best_s = s;
                        best = i;
                    end
                end
                bx = have ? pred_vtx[best][0] : 32'sd0;
                by = have ? pred_vtx[best][1] : 32'sd0;
                bz = have ? pred_vtx[best][2] : 32'sd0;
                exp_pt = '{mat_row(pred_place, 0, bx, by, bz, 1),
                    mat_row(pred_place, 1, bx, by, bz, 1),
                    mat_row(pred_place, 2, bx, by, bz, 1), 10'(best), have};
                support_q.insert(support_q.size(), exp_pt);
            end
        endcase
    endfunction

    // Driver: bursts and gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge clk)
    begin
        if (!in_valid || in_ready)
        begin
            if (pending_q.size() != 0 && gap_left == 0)
            begin
                hull_txn_t t;
                t = pending_q.pop_front();
                predict_support(t);
                in_valid <= 1'b1;
                opcode <= t.op;
                slot <= t.slot;
                coord_x <= t.cx;
                coord_y <= t.cy;
                coord_z <= t.cz;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 8);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
        end
    end

    // Receiver stall pattern and result check
    int stall_phase = 0;
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (support_q.size() == 0)
            begin
                $error("unexpected support point idx=%0d", chosen_vertex);
                n_fail++;
            end
            else
            begin
                support_t e;
                e = support_q.pop_front();
                if (point_x !== e.px)
                begin $error("point_x exp %0d got %0d", e.px, point_x); n_fail++; end
                if (point_y !== e.py)
                begin $error("point_y exp %0d got %0d", e.py, point_y); n_fail++; end
                if (point_z !== e.pz)
                begin $error("point_z exp %0d got %0d", e.pz, point_z); n_fail++; end
                if (chosen_vertex !== e.idx)
                begin
                    $error("chosen_vertex exp %0d got %0d", e.idx, chosen_vertex);
                    n_fail++;
                end
                if (found !== e.hit)
                begin $error("found exp %0d got %0d", e.hit, found); n_fail++; end
            end
        end
        stall_phase = (stall_phase + 1) % 64;
        out_ready <= (stall_phase < 16) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    // Watchdog on accepted transactions
    always @(posedge clk)
    begin
        txn_seen = (in_valid && in_ready) || (out_valid && out_ready) ||
                   (cfg_valid && cfg_ready);
        if (txn_seen || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic add_txn(opcode_t op, int s, logic signed [31:0] x,
                           logic signed [31:0] y, logic signed [31:0] z);
        hull_txn_t t;
        t = '{op, 10'(s), x, y, z};
        pending_q.insert(pending_q.size(), t);
    endtask

    // hold until driver and checker are drained, then write the count
    task automatic write_count(logic [10:0] n);
        wait (pending_q.size() == 0);
        @(posedge clk);
        while (in_valid || support_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= n;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        pred_count = n;
    endtask

    task automatic random_phase(int items, int nv);
        for (int k = 0; k < items; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: add_txn(OP_LOAD_VERTEX, $urandom_range(0, nv - 1),
                    rand_coord(), rand_coord(), rand_coord());
                3: add_txn(OP_LOAD_PLACE, $urandom_range(0, 13), rand_coord(), $urandom(), $urandom());
                4: add_txn(OP_LOAD_INV, $urandom_range(0, 13), rand_coord(), $urandom(), $urandom());
                default: add_txn(OP_QUERY, $urandom_range(0, 1023),
                    rand_coord(), rand_coord(), rand_coord());
            endcase
        end
    endtask

    initial
    begin
        reset_matrices();
        pred_count = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty hull, then extremes and ties
        add_txn(OP_QUERY, 0, 32'sd65536, 0, 0);
        add_txn(OP_LOAD_PLACE, 3, 32'sh7fffffff, 0, 0);
        add_txn(OP_LOAD_PLACE, 12, 32'sd5, 0, 0);
        add_txn(OP_LOAD_INV, 15, 32'sd5, 0, 0);
        add_txn(OP_QUERY, 1023, 0, 0, 0);
        for (int i = 0; i < 4; i++)
            add_txn(OP_LOAD_VERTEX, i, (i == 3) ? 32'sh80000000 : 32'sh7fffffff,
                32'sh80000000, i * 32'sd65536);
        add_txn(OP_LOAD_VERTEX, 1023, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        write_count(11'd4);
        add_txn(OP_QUERY, 0, 0, 0, 0);
        add_txn(OP_QUERY, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        add_txn(OP_QUERY, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        add_txn(OP_LOAD_INV, 0, 32'sh80000000, 0, 0);
        add_txn(OP_LOAD_PLACE, 11, 32'sh80000000, 0, 0);
        add_txn(OP_QUERY, 0, 32'sd65536, 32'sd1, 32'sd1);
        add_txn(OP_LOAD_PLACE, 0, 32'sh7fffffff, 0, 0);
        add_txn(OP_LOAD_INV, 11, 32'sh7fffffff, 0, 0);
        add_txn(OP_QUERY, 0, 32'sh80000000, 0, 0);

        // fill the low slots, so every count up to NV_USED is safe to read
        for (int i = 0; i < NV_USED; i++)
            add_txn(OP_LOAD_VERTEX, i, rand_coord(), rand_coord(), rand_coord());
        write_count(11'(NV_USED));
        add_txn(OP_QUERY, 0, 32'sd65536, 32'sd65536, 32'sd65536);
        add_txn(OP_QUERY, 0, 32'sh80000000, 32'sd3, 32'sh7fffffff);
        add_txn(OP_QUERY, 0, 32'sd7, 32'sh80000000, 32'sd0);

        // Random phases, mostly small hulls
        write_count(11'd1);
        random_phase(90, NV_USED);
        write_count(11'd8);
        random_phase(120, NV_USED);
        write_count(11'd0);
        random_phase(50, NV_USED);
        write_count(11'(16 + $urandom_range(0, 48)));
        random_phase(120, NV_USED);
        write_count(11'd3);
        random_phase(92, NV_USED);
        write_count(11'(NV_USED));
        random_phase(8, NV_USED);

        // drain
        wait (pending_q.size() == 0);
        @(posedge clk);
        while (in_valid || support_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (n_fail == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
